FILE: hw/rtl/crc8_response_frame_receiver_top_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the CRC-8 response frame receiver
// Shared concurrent assertion forms, clocked on clock and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef CRC8_RESPONSE_FRAME_RECEIVER_TOP_MACROS_SVH
`define CRC8_RESPONSE_FRAME_RECEIVER_TOP_MACROS_SVH

// Same-cycle implication.
`define CRC8RX_ASSERT_IMP(name, ante, cons) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("crc8rx assertion failed");

// Next-cycle implication.
`define CRC8RX_ASSERT_NXT(name, ante, cons) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("crc8rx assertion failed");

`endif

FILE: hw/rtl/crc8rx_pkg.sv
// ----------------------------------------------------------------------------
// crc8rx_pkg
// Types, codes and the CRC-8 step shared by the frame receiver modules.
// ----------------------------------------------------------------------------
`default_nettype none

package crc8rx_pkg;

   localparam int FRAME_BUFFER_BYTES_DEFAULT = 256;

   localparam logic [7:0]  START_BYTE_RESET    = 8'hAA;
   localparam logic [7:0]  END_BYTE_RESET      = 8'h55;
   localparam logic [15:0] TIMEOUT_TICKS_RESET = 16'd1000;
   localparam logic [7:0]  OK_STATUS_RESET     = 8'h00;

   localparam logic [7:0]  CRC_INIT     = 8'hFF;
   localparam logic [7:0]  CRC_POLY     = 8'h31;
   localparam logic [7:0]  REPLY_FLAG   = 8'h80;

   // Item kinds on the request channel.
   localparam logic [1:0] CMD_ARM  = 2'd0;
   localparam logic [1:0] CMD_BYTE = 2'd1;
   localparam logic [1:0] CMD_TICK = 2'd2;

   // Configuration register indexes.
   localparam logic [1:0] REG_START_BYTE    = 2'd0;
   localparam logic [1:0] REG_END_BYTE      = 2'd1;
   localparam logic [1:0] REG_TIMEOUT_TICKS = 2'd2;
   localparam logic [1:0] REG_OK_STATUS     = 2'd3;

   // Result kinds.
   localparam logic RES_DATA = 1'b0;
   localparam logic RES_DONE = 1'b1;

   // Completion outcomes.
   localparam logic [1:0] OUTCOME_STATUS  = 2'd0;
   localparam logic [1:0] OUTCOME_FRAME   = 2'd1;
   localparam logic [1:0] OUTCOME_CRC     = 2'd2;
   localparam logic [1:0] OUTCOME_TIMEOUT = 2'd3;

   typedef struct packed {
      logic [7:0]  start_byte;
      logic [7:0]  end_byte;
      logic [15:0] timeout_ticks;
      logic [7:0]  ok_status;
   } cfg_type;

   typedef struct packed {
      logic        result_kind;
      logic [7:0]  data_byte;
      logic [1:0]  outcome;
      logic [7:0]  device_status;
      logic        success;
      logic [15:0] copied_length;
   } rsp_item_type;

   // One byte of CRC-8, MSB first, no reflection.
   function automatic logic [7:0] crc_step(input logic [7:0] crc, input logic [7:0] b);
      logic [7:0] c;
      c = crc ^ b;
      for (int k = 0; k < 8; k++) begin
         if (c[7]) begin
            c = {c[6:0], 1'b0} ^ CRC_POLY;
         end else begin
            c = {c[6:0], 1'b0};
         end
      end
      return c;
   endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/crc8rx_parser.sv
// ----------------------------------------------------------------------------
// crc8rx_parser
// Frame state machine: hunts, parses header, checks CRC, forwards data, times out.
// ----------------------------------------------------------------------------
`default_nettype none

module crc8rx_parser #(
   parameter int FRAME_BUFFER_BYTES = crc8rx_pkg::FRAME_BUFFER_BYTES_DEFAULT
) (
   input  wire                       clock,
   input  wire                       reset,
   input  wire                       step,
   input  wire  [1:0]                cmd,
   input  wire  [7:0]                command_code,
   input  wire  [15:0]               response_capacity,
   input  wire  [7:0]                byte_value,
   input  wire  crc8rx_pkg::cfg_type cfg,
   output logic                      res_valid,
   output crc8rx_pkg::rsp_item_type  res
);

   localparam int IDX_W = $clog2(FRAME_BUFFER_BYTES);
   localparam logic [16:0] FRAME_MAX = 17'(FRAME_BUFFER_BYTES);

   typedef enum logic [1:0] {
      PH_IDLE = 2'd0,
      PH_HUNT = 2'd1,
      PH_RECV = 2'd2
   } phase_type;

   phase_type    phase_ff, phase_in;
   logic [IDX_W-1:0] idx_ff, idx_in;
   logic [15:0]  plen_ff, plen_in;
   logic [7:0]   reply_ff, reply_in;
   logic [7:0]   crc_ff, crc_in;
   logic [7:0]   rcrc_ff, rcrc_in;
   logic [7:0]   expect_ff, expect_in;
   logic [15:0]  cap_ff, cap_in;
   logic [15:0]  fwd_ff, fwd_in;
   logic [7:0]   status_ff, status_in;
   logic [15:0]  tick_ff, tick_in;

   logic [16:0]  idx_ext;
   logic [16:0]  pos;
   logic [15:0]  plen_new;
   logic         done;
   logic [1:0]   done_outcome;

   assign idx_ext  = 17'(idx_ff);
   assign pos      = idx_ext - 17'd4;
   assign plen_new = {plen_ff[15:8], byte_value};

   always_comb begin
      phase_in     = phase_ff;
      idx_in       = idx_ff;
      plen_in      = plen_ff;
      reply_in     = reply_ff;
      crc_in       = crc_ff;
      rcrc_in      = rcrc_ff;
      expect_in    = expect_ff;
      cap_in       = cap_ff;
      fwd_in       = fwd_ff;
      status_in    = status_ff;
      tick_in      = tick_ff;
      res_valid    = 1'b0;
      res          = '0;
      done         = 1'b0;
      done_outcome = crc8rx_pkg::OUTCOME_STATUS;

      if (step) begin
         case (cmd)
            crc8rx_pkg::CMD_ARM: begin
               phase_in  = PH_HUNT;
               idx_in    = '0;
               plen_in   = '0;
               reply_in  = '0;
               crc_in    = crc8rx_pkg::CRC_INIT;
               rcrc_in   = '0;
               status_in = '0;
               expect_in = command_code;
               cap_in    = response_capacity;
               fwd_in    = '0;
               tick_in   = '0;
            end
            crc8rx_pkg::CMD_BYTE: begin
               if (phase_ff == PH_HUNT) begin
                  if (byte_value == cfg.start_byte) begin
                     phase_in  = PH_RECV;
                     idx_in    = IDX_W'(1);
                     plen_in   = '0;
                     reply_in  = '0;
                     crc_in    = crc8rx_pkg::CRC_INIT;
                     rcrc_in   = '0;
                     status_in = '0;
                  end
               end else if (phase_ff == PH_RECV) begin
                  idx_in = idx_ff + IDX_W'(1);
                  if (idx_ext == 17'd1) begin
                     reply_in = byte_value;
                  end else if (idx_ext == 17'd2) begin
                     plen_in = {byte_value, 8'h00};
                  end else if (idx_ext == 17'd3) begin
                     plen_in = plen_new;
                     // Frame would not fit the buffer: drop it and hunt again.
                     if ((17'(plen_new) + 17'd6) > FRAME_MAX) begin
                        phase_in  = PH_HUNT;
                        idx_in    = '0;
                        plen_in   = '0;
                        reply_in  = '0;
                        crc_in    = crc8rx_pkg::CRC_INIT;
                        rcrc_in   = '0;
                        status_in = '0;
                     end
                  end else begin
                     if (idx_ext == 17'd4) begin
                        status_in = byte_value;
                     end
                     if (pos < 17'(plen_ff)) begin
                        crc_in = crc8rx_pkg::crc_step(crc_ff, byte_value);
                        if (pos != 17'd0 && cap_ff != 16'd0) begin
                           cap_in              = cap_ff - 16'd1;
                           fwd_in              = fwd_ff + 16'd1;
                           res_valid           = 1'b1;
                           res.result_kind     = crc8rx_pkg::RES_DATA;
                           res.data_byte       = byte_value;
                        end
                     end else if (pos == 17'(plen_ff)) begin
                        rcrc_in = byte_value;
                     end else begin
                        done = 1'b1;
                        if (byte_value != cfg.end_byte) begin
                           done_outcome = crc8rx_pkg::OUTCOME_FRAME;
                        end else if (reply_ff != (expect_ff | crc8rx_pkg::REPLY_FLAG)) begin
                           done_outcome = crc8rx_pkg::OUTCOME_FRAME;
                        end else if (rcrc_ff != crc_ff) begin
                           done_outcome = crc8rx_pkg::OUTCOME_CRC;
                        end else begin
                           done_outcome = crc8rx_pkg::OUTCOME_STATUS;
                        end
                     end
                  end
               end
            end
            crc8rx_pkg::CMD_TICK: begin
               if (phase_ff != PH_IDLE) begin
                  if (tick_ff != 16'hFFFF) begin
                     tick_in = tick_ff + 16'd1;
                  end
                  if (tick_in >= cfg.timeout_ticks) begin
                     done         = 1'b1;
                     done_outcome = crc8rx_pkg::OUTCOME_TIMEOUT;
                  end
               end
            end
            default: begin
            end
         endcase

         if (done) begin
            phase_in          = PH_IDLE;
            res_valid         = 1'b1;
            res.result_kind   = crc8rx_pkg::RES_DONE;
            res.outcome       = done_outcome;
            res.copied_length = fwd_ff;
            if (done_outcome == crc8rx_pkg::OUTCOME_STATUS) begin
               res.device_status = status_ff;
               res.success       = (status_ff == cfg.ok_status);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_IDLE;
         idx_ff    <= '0;
         plen_ff   <= '0;
         reply_ff  <= '0;
         crc_ff    <= crc8rx_pkg::CRC_INIT;
         rcrc_ff   <= '0;
         expect_ff <= '0;
         cap_ff    <= '0;
         fwd_ff    <= '0;
         status_ff <= '0;
         tick_ff   <= '0;
      end else begin
         phase_ff  <= phase_in;
         idx_ff    <= idx_in;
         plen_ff   <= plen_in;
         reply_ff  <= reply_in;
         crc_ff    <= crc_in;
         rcrc_ff   <= rcrc_in;
         expect_ff <= expect_in;
         cap_ff    <= cap_in;
         fwd_ff    <= fwd_in;
         status_ff <= status_in;
         tick_ff   <= tick_in;
      end
   end

`include "crc8_response_frame_receiver_top_macros.svh"

   `CRC8RX_ASSERT_NXT(a_done_goes_idle, step && res_valid && res.result_kind == crc8rx_pkg::RES_DONE, phase_ff == PH_IDLE)
   `CRC8RX_ASSERT_IMP(a_recv_index_nonzero, phase_ff == PH_RECV, idx_ff != '0)
   `CRC8RX_ASSERT_IMP(a_data_needs_capacity, res_valid && res.result_kind == crc8rx_pkg::RES_DATA, cap_ff != 16'd0 && phase_ff == PH_RECV)

endmodule

`default_nettype wire

FILE: hw/rtl/crc8_response_frame_receiver_top.sv
// ----------------------------------------------------------------------------
// crc8_response_frame_receiver_top
// Reply-frame receiver for a serial command link with CRC-8 payload check.
// ----------------------------------------------------------------------------
// Usage: the request stream carries three kinds of transaction, chosen by
// req_tuser: an arm (loads the expected command code and the response
// capacity and starts hunting for the start byte), a received serial byte,
// and a one millisecond tick. The response stream returns either forwarded
// payload data bytes (every payload byte after the status byte, up to the
// capacity) or at most one completion per armed transaction, reporting status
// returned, frame/echo error, CRC error or timeout.
// A request passes through the input register and then through the frame
// logic into the output register. Throughput is one transaction per cycle
// while the output register is free or being emptied by the response side.
// When the response side stalls, the output register holds its transaction
// and the input register fills; req_tready drops only when both are full.
// Reset (synchronous, active high) restores the register defaults and leaves
// the receiver idle: bytes and ticks are ignored until the next arm.
// The csr_ port writes the configuration registers; write it only while idle.
// ----------------------------------------------------------------------------
`default_nettype none

module crc8_response_frame_receiver_top #(
   parameter int FRAME_BUFFER_BYTES = crc8rx_pkg::FRAME_BUFFER_BYTES_DEFAULT
) (
   input  wire         clock,
   input  wire         reset,
   // Request channel.
   input  wire         req_tvalid,
   output logic        req_tready,
   // [7:0] command_code, [23:8] response_capacity, [31:24] byte_value
   input  wire  [31:0] req_tdata,
   // [1:0] cmd
   input  wire  [1:0]  req_tuser,
   // Response channel.
   output logic        rsp_tvalid,
   input  wire         rsp_tready,
   // [7:0] data_byte, [9:8] outcome, [17:10] device_status, [18] success,
   // [34:19] copied_length, [39:35] zero
   output logic [39:0] rsp_tdata,
   // [0] result_kind
   output logic        rsp_tuser,
   // Configuration write port.
   input  wire         csr_we,
   input  wire  [1:0]  csr_index,
   input  wire  [15:0] csr_wdata
);

   // Configuration registers.
   crc8rx_pkg::cfg_type cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.start_byte    <= crc8rx_pkg::START_BYTE_RESET;
         cfg_ff.end_byte      <= crc8rx_pkg::END_BYTE_RESET;
         cfg_ff.timeout_ticks <= crc8rx_pkg::TIMEOUT_TICKS_RESET;
         cfg_ff.ok_status     <= crc8rx_pkg::OK_STATUS_RESET;
      end else if (csr_we) begin
         case (csr_index)
            crc8rx_pkg::REG_START_BYTE:    cfg_ff.start_byte    <= csr_wdata[7:0];
            crc8rx_pkg::REG_END_BYTE:      cfg_ff.end_byte      <= csr_wdata[7:0];
            crc8rx_pkg::REG_TIMEOUT_TICKS: cfg_ff.timeout_ticks <= csr_wdata;
            crc8rx_pkg::REG_OK_STATUS:     cfg_ff.ok_status     <= csr_wdata[7:0];
            default: begin
            end
         endcase
      end
   end

   // Input register: one request transaction waiting for the frame logic.
   logic        in_valid_ff;
   logic [1:0]  in_cmd_ff;
   logic [7:0]  in_code_ff;
   logic [15:0] in_cap_ff;
   logic [7:0]  in_byte_ff;

   // Output register: one response transaction waiting for the consumer.
   logic                     out_valid_ff;
   crc8rx_pkg::rsp_item_type out_item_ff;

   logic                     advance;
   logic                     res_valid;
   crc8rx_pkg::rsp_item_type res;

   // The frame logic consumes the input register whenever the output
   // register is free or is being emptied in this cycle.
   assign advance    = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_cmd_ff  <= req_tuser;
         in_code_ff <= req_tdata[7:0];
         in_cap_ff  <= req_tdata[23:8];
         in_byte_ff <= req_tdata[31:24];
      end
   end

   crc8rx_parser #(
      .FRAME_BUFFER_BYTES(FRAME_BUFFER_BYTES)
   ) u_parser (
      .clock             (clock),
      .reset             (reset),
      .step              (advance),
      .cmd               (in_cmd_ff),
      .command_code      (in_code_ff),
      .response_capacity (in_cap_ff),
      .byte_value        (in_byte_ff),
      .cfg               (cfg_ff),
      .res_valid         (res_valid),
      .res               (res)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance && res_valid) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && res_valid) begin
         out_item_ff <= res;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tuser  = out_item_ff.result_kind;
   assign rsp_tdata  = {5'b00000,
                        out_item_ff.copied_length,
                        out_item_ff.success,
                        out_item_ff.device_status,
                        out_item_ff.outcome,
                        out_item_ff.data_byte};

`include "crc8_response_frame_receiver_top_macros.svh"

   `CRC8RX_ASSERT_IMP(a_success_means_ok, out_valid_ff && out_item_ff.success, out_item_ff.outcome == crc8rx_pkg::OUTCOME_STATUS && out_item_ff.device_status == cfg_ff.ok_status)
   `CRC8RX_ASSERT_IMP(a_data_has_no_status, out_valid_ff && out_item_ff.result_kind == crc8rx_pkg::RES_DATA, out_item_ff.outcome == crc8rx_pkg::OUTCOME_STATUS && out_item_ff.copied_length == 16'd0)
   `CRC8RX_ASSERT_NXT(a_stall_keeps_input, in_valid_ff && !advance, in_valid_ff && $stable(in_cmd_ff) && $stable(in_byte_ff))

endmodule

`default_nettype wire

FILE: dv/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: CRC-8 response frame receiver testbench
// Drives arm, byte and tick transactions into the receiver, predicts every
// forwarded data byte and completion with an independent frame tracker, and
// compares the response stream field by field under random back-pressure.
// ----------------------------------------------------------------------------

module tb;

   // Item kind 3 is not decoded by the receiver.
   localparam logic [1:0] CMD_UNUSED = 2'd3;

   // Cycles to let pass after the last expected response, so that items
   // that produce nothing have left the two pipeline registers.
   localparam int DRAIN_CYCLES = 8;

   // This limit leaves a wide margin over the slowest correct run for stalls
   // and idle gaps.
   localparam int unsigned CYCLE_LIMIT = 200000;

   typedef enum logic [1:0] {RX_IDLE, RX_HUNT, RX_RECV} rx_phase_type;

   // Ways in which a generated reply frame is damaged.
   typedef enum int {FAULT_NONE, FAULT_END, FAULT_CRC, FAULT_CUT} fault_type;

   // -------------------------------------------------------------------------
   // Frame tracker: follows the receiver state transaction by transaction and
   // keeps the responses that are still awaited from the block.
   // -------------------------------------------------------------------------
   class receiver_tracker;
      logic [7:0]   start_b;
      logic [7:0]   end_b;
      logic [15:0]  timeout;
      logic [7:0]   ok_stat;

      rx_phase_type phase;
      logic [16:0]  idx;
      logic [15:0]  pay_len;
      logic [7:0]   reply_cmd;
      logic [7:0]   crc;
      logic [7:0]   rx_crc;
      logic [7:0]   exp_cmd;
      logic [15:0]  cap_left;
      logic [15:0]  fwd_cnt;
      logic [7:0]   status;
      logic [15:0]  ticks;

      crc8rx_pkg::rsp_item_type awaited_replies[$];
      int unsigned  errors;

      function new();
         start_b = crc8rx_pkg::START_BYTE_RESET;
         end_b = crc8rx_pkg::END_BYTE_RESET;
         timeout = crc8rx_pkg::TIMEOUT_TICKS_RESET;
         ok_stat = crc8rx_pkg::OK_STATUS_RESET;
         phase = RX_IDLE;
         clear_frame();
         exp_cmd = '0;
         cap_left = '0;
         fwd_cnt = '0;
         ticks = '0;
         errors = 0;
      endfunction

      // CRC-8, poly 0x31, processed one bit at a time from the MSB.
      static function logic [7:0] crc_byte(logic [7:0] c, logic [7:0] b);
         logic fb;
         for (int i = 7; i >= 0; i--) begin
            fb = c[7] ^ b[i];
            c = {c[6:0], 1'b0};
            if (fb) begin
               c = c ^ crc8rx_pkg::CRC_POLY;
            end
         end
         return c;
      endfunction

      function void set_reg(logic [1:0] index, logic [15:0] value);
         case (index)
            crc8rx_pkg::REG_START_BYTE:    start_b = value[7:0];
            crc8rx_pkg::REG_END_BYTE:      end_b = value[7:0];
            crc8rx_pkg::REG_TIMEOUT_TICKS: timeout = value;
            crc8rx_pkg::REG_OK_STATUS:     ok_stat = value[7:0];
            default: ;
         endcase
      endfunction

      function void clear_frame();
         idx = '0;
         pay_len = '0;
         reply_cmd = '0;
         crc = crc8rx_pkg::CRC_INIT;
         rx_crc = '0;
         status = '0;
      endfunction

      // A completion ends the transaction; the block idles until the next arm.
      function void close_transaction(logic [1:0] outcome);
         crc8rx_pkg::rsp_item_type r;
         logic good;
         good = (outcome == crc8rx_pkg::OUTCOME_STATUS);
         r = '0;
         r.result_kind = crc8rx_pkg::RES_DONE;
         r.outcome = outcome;
         r.device_status = good ? status : 8'h00;
         r.success = good && (status == ok_stat);
         r.copied_length = fwd_cnt;
         awaited_replies.push_back(r);
         phase = RX_IDLE;
      endfunction

      // Takes one accepted request transaction. Returns 1 unless the block
      // simply ignores it.
      function bit take_request(logic [1:0] kind, logic [7:0] code,
                                logic [15:0] cap, logic [7:0] b);
         logic [16:0] pos;
         logic [16:0] p;
         crc8rx_pkg::rsp_item_type r;
         if (kind == crc8rx_pkg::CMD_ARM) begin
            clear_frame();
            exp_cmd = code;
            cap_left = cap;
            fwd_cnt = '0;
            ticks = '0;
            phase = RX_HUNT;
            return 1'b1;
         end
         if (phase == RX_IDLE || kind == CMD_UNUSED) begin
            return 1'b0;
         end
         if (kind == crc8rx_pkg::CMD_TICK) begin
            if (ticks != 16'hFFFF) begin
               ticks = ticks + 16'd1;
            end
            if (ticks >= timeout) begin
               close_transaction(crc8rx_pkg::OUTCOME_TIMEOUT);
            end
            return 1'b1;
         end
         // Received serial byte.
         if (phase == RX_HUNT) begin
            if (b == start_b) begin
               clear_frame();
               phase = RX_RECV;
               idx = 17'd1;
            end
            return 1'b1;
         end
         pos = idx;
         idx = idx + 17'd1;
         if (pos == 17'd1) begin
            reply_cmd = b;
         end else if (pos == 17'd2) begin
            pay_len = {b, 8'h00};
         end else if (pos == 17'd3) begin
            pay_len = {pay_len[15:8], b};
            // Frames that do not fit the buffer are dropped after the header.
            if (int'(pay_len) + 6 > crc8rx_pkg::FRAME_BUFFER_BYTES_DEFAULT) begin
               clear_frame();
               phase = RX_HUNT;
            end
         end else begin
            if (pos == 17'd4) begin
               status = b;
            end
            p = pos - 17'd4;
            if (p < 17'(pay_len)) begin
               crc = crc_byte(crc, b);
               if (p >= 17'd1 && cap_left != 16'd0) begin
                  cap_left = cap_left - 16'd1;
                  fwd_cnt = fwd_cnt + 16'd1;
                  r = '0;
                  r.result_kind = crc8rx_pkg::RES_DATA;
                  r.data_byte = b;
                  awaited_replies.push_back(r);
               end
            end else if (p == 17'(pay_len)) begin
               rx_crc = b;
            end else if (b != end_b || reply_cmd != (exp_cmd | crc8rx_pkg::REPLY_FLAG)) begin
               close_transaction(crc8rx_pkg::OUTCOME_FRAME);
            end else if (rx_crc != crc) begin
               close_transaction(crc8rx_pkg::OUTCOME_CRC);
            end else begin
               close_transaction(crc8rx_pkg::OUTCOME_STATUS);
            end
         end
         return 1'b1;
      endfunction

      function void check_reply(logic kind, logic [39:0] data);
         crc8rx_pkg::rsp_item_type got;
         crc8rx_pkg::rsp_item_type want;
         got.result_kind = kind;
         got.data_byte = data[7:0];
         got.outcome = data[9:8];
         got.device_status = data[17:10];
         got.success = data[18];
         got.copied_length = data[34:19];
         if (awaited_replies.size() == 0) begin
            errors++;
            if (errors <= 10) begin
               $display("%0t: response with none awaited: kind=%0d data=%010h",
                        $realtime, kind, data);
            end
            return;
         end
         want = awaited_replies.pop_front();
         if (got !== want) begin
            errors++;
            if (errors <= 10) begin
               $display("%0t: mismatch, expected kind=%0d byte=%02h outcome=%0d",
                        $realtime, want.result_kind, want.data_byte, want.outcome);
               $display("   status=%02h success=%0d copied=%0d", want.device_status,
                        want.success, want.copied_length);
               $display("   got kind=%0d byte=%02h outcome=%0d status=%02h",
                        got.result_kind, got.data_byte, got.outcome,
                        got.device_status);
               $display("   success=%0d copied=%0d", got.success, got.copied_length);
            end
         end
      endfunction

      function int pending();
         return awaited_replies.size();
      endfunction
   endclass

   // -------------------------------------------------------------------------
   // Block under test and its drivers. All inputs start at known values.
   // -------------------------------------------------------------------------
   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata = '0;
   logic [1:0]  req_tuser = crc8rx_pkg::CMD_ARM;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [39:0] rsp_tdata;
   logic        rsp_tuser;
   logic        csr_we = 1'b0;
   logic [1:0]  csr_index = crc8rx_pkg::REG_START_BYTE;
   logic [15:0] csr_wdata = '0;

   receiver_tracker sb = new();

   // Random idling on both sides can be switched off for a stretch.
   bit          idle_on = 1'b1;
   // Percentage chance of a tick between the bytes of a generated frame.
   int unsigned tick_mix = 0;
   // A nonzero value asks the response side to hold off for that many cycles.
   int unsigned hold_req = 0;
   // Transactions that the block acted on (ignored ones are not counted).
   int unsigned n_used = 0;
   int unsigned cycle_count = 0;

   crc8_response_frame_receiver_top uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always #1 clock = ~clock;

   // Watchdog: a hung handshake ends the run as a failure.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   // Response side. Each accepted transaction is checked against the oldest
   // awaited response. Ready drops at random, or for a long hold-off when the
   // stimulus asks for one; the hold-off is counted here, cycle by cycle.
   initial begin
      int unsigned hold_left;
      hold_left = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_tvalid && rsp_tready) begin
            sb.check_reply(rsp_tuser, rsp_tdata);
         end
         if (hold_req != 0) begin
            hold_left = hold_req;
            hold_req = 0;
         end
         if (hold_left != 0) begin
            rsp_tready <= 1'b0;
            hold_left--;
         end else begin
            rsp_tready <= !(idle_on && $urandom_range(99) < 24);
         end
      end
   end

   // Offers one request transaction, after a random idle gap, and returns at
   // the edge where it was accepted. Fields the kind does not use carry
   // whatever the caller passes, mostly random values.
   task automatic send_item(input logic [1:0] kind, input logic [7:0] code,
                            input logic [15:0] cap, input logic [7:0] b);
      while (idle_on && $urandom_range(99) < 24) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= kind;
      req_tdata <= {b, cap, code};
      do begin
         @(posedge clock);
      end while (!req_tready);
      if (sb.take_request(kind, code, cap, b)) begin
         n_used++;
      end
   endtask

   task automatic arm(input logic [7:0] code, input logic [15:0] cap);
      send_item(crc8rx_pkg::CMD_ARM, code, cap, 8'($urandom));
   endtask

   task automatic send_byte(input logic [7:0] b);
      send_item(crc8rx_pkg::CMD_BYTE, 8'($urandom), 16'($urandom), b);
   endtask

   task automatic tick();
      send_item(crc8rx_pkg::CMD_TICK, 8'($urandom), 16'($urandom), 8'($urandom));
   endtask

   // The sender stops and waits until every awaited response has come back,
   // then lets the pipeline empty.
   task automatic pause_until_drained();
      req_tvalid <= 1'b0;
      while (sb.pending() != 0) begin
         @(posedge clock);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Leaves the write enable high; the caller lowers it after the last write.
   task automatic write_reg(input logic [1:0] index, input logic [15:0] value);
      csr_we <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(posedge clock);
      sb.set_reg(index, value);
   endtask

   // Registers are only written with the block drained.
   task automatic configure(input logic [7:0] start_v, input logic [7:0] end_v,
                            input logic [15:0] timeout_v, input logic [7:0] ok_v);
      pause_until_drained();
      write_reg(crc8rx_pkg::REG_START_BYTE, {8'($urandom_range(255)), start_v});
      write_reg(crc8rx_pkg::REG_END_BYTE, {8'($urandom_range(255)), end_v});
      write_reg(crc8rx_pkg::REG_TIMEOUT_TICKS, timeout_v);
      write_reg(crc8rx_pkg::REG_OK_STATUS, {8'($urandom_range(255)), ok_v});
      csr_we <= 1'b0;
   endtask

   // Sends a reply frame with the given command echo and payload length.
   // Payload bytes are random, with the start and end values mixed in, and
   // the status byte often equals the success value. A frame too long for
   // the buffer is sent as its header only, since the block drops it there.
   task automatic send_frame(input logic [7:0] echo, input logic [15:0] len,
                             input fault_type fault);
      logic [7:0] body[$];
      logic [7:0] c;
      logic [7:0] b;
      int         stop;
      body.push_back(sb.start_b);
      body.push_back(echo);
      body.push_back(len[15:8]);
      body.push_back(len[7:0]);
      if (int'(len) + 6 <= crc8rx_pkg::FRAME_BUFFER_BYTES_DEFAULT) begin
         c = crc8rx_pkg::CRC_INIT;
         for (int i = 0; i < int'(len); i++) begin
            case ($urandom_range(7))
               0: b = sb.start_b;
               1: b = sb.end_b;
               default: b = 8'($urandom);
            endcase
            if (i == 0 && $urandom_range(1) == 1) begin
               b = sb.ok_stat;
            end
            body.push_back(b);
            c = receiver_tracker::crc_byte(c, b);
         end
         body.push_back((fault == FAULT_CRC) ? c ^ (8'h01 << $urandom_range(7)) : c);
         body.push_back((fault == FAULT_END) ? sb.end_b ^ (8'h01 << $urandom_range(7))
                                             : sb.end_b);
      end
      stop = (fault == FAULT_CUT) ? int'($urandom_range(1, body.size() - 1))
                                  : body.size();
      for (int i = 0; i < stop; i++) begin
         if ($urandom_range(99) < tick_mix) begin
            tick();
         end
         send_byte(body[i]);
      end
   endtask

   // -------------------------------------------------------------------------
   // Stimulus.
   // -------------------------------------------------------------------------
   initial begin
      logic [7:0]  code;
      logic [7:0]  echo;
      logic [15:0] cap;
      logic [15:0] len;
      fault_type   fault;
      int unsigned r;
      int unsigned target;

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Bytes, ticks and the unused kind while idle are ignored.
      send_byte(8'hAA);
      tick();
      send_item(CMD_UNUSED, 8'hFF, 16'hFFFF, 8'hFF);
      send_byte(8'h00);

      // A clean reply that forwards two data bytes.
      arm(8'h01, 16'd4);
      send_frame(8'h81, 16'd3, FAULT_NONE);

      // Empty payload: the CRC byte sits where the status would be.
      arm(8'h7F, 16'd4);
      send_frame(8'hFF, 16'd0, FAULT_NONE);

      // Noise before the start byte, zero capacity and a wrong end byte.
      arm(8'h02, 16'd0);
      send_byte(8'h00);
      send_byte(8'hFF);
      send_frame(8'h82, 16'd5, FAULT_END);

      // A wrong echo is reported ahead of a CRC error; then a bare CRC error.
      arm(8'h03, 16'd3);
      send_frame(8'h13, 16'd4, FAULT_CRC);
      arm(8'h04, 16'd2);
      send_frame(8'h84, 16'd6, FAULT_CRC);

      // An oversized frame is dropped after its header; hunting resumes.
      arm(8'h05, 16'd8);
      send_frame(8'h85, 16'd251, FAULT_NONE);
      send_frame(8'h85, 16'd2, FAULT_NONE);

      // The longest frame that fits the buffer.
      arm(8'h06, 16'hFFFF);
      send_frame(8'h86, 16'd250, FAULT_NONE);

      // A new arm abandons a transaction in the middle of its frame.
      arm(8'h07, 16'd3);
      send_frame(8'h87, 16'd8, FAULT_CUT);
      arm(8'h08, 16'd3);
      send_frame(8'h88, 16'd4, FAULT_NONE);

      // Timeouts, one in the middle of a frame, possibly after forwarding.
      configure(crc8rx_pkg::START_BYTE_RESET, crc8rx_pkg::END_BYTE_RESET, 16'd3,
                crc8rx_pkg::OK_STATUS_RESET);
      arm(8'h09, 16'hFFFF);
      tick();
      tick();
      send_frame(8'h89, 16'd10, FAULT_CUT);
      tick();
      arm(8'h0A, 16'd1);
      repeat (4) tick();

      // The response side holds off while a long frame streams in, so the
      // block fills up and stalls its request side.
      arm(8'h10, 16'hFFFF);
      hold_req = 80;
      send_frame(8'h90, 16'd40, FAULT_NONE);

      // Register extremes; a zero timeout expires on the first tick.
      configure(8'h00, 8'hFF, 16'd0, 8'hFF);
      arm(8'hFF, 16'hFFFF);
      tick();
      arm(8'h00, 16'h8000);
      send_frame(8'h80, 16'd7, FAULT_NONE);

      // The longest timeout; a burst of ticks with no idling on either side
      // stays short of it, and the next arm abandons the transaction.
      configure(8'hFF, 8'h00, 16'hFFFF, 8'h00);
      arm(8'h5A, 16'd1);
      send_frame(8'hDA, 16'd3, FAULT_NONE);
      idle_on = 1'b0;
      arm(8'h5B, 16'd5);
      repeat (60) tick();
      idle_on = 1'b1;

      // Random part in four register settings. Most transactions are well
      // formed frames with random content; the rest are timeouts, abandoned
      // frames, broken frames and noise.
      target = n_used;
      for (int ph = 0; ph < 4; ph++) begin
         configure(8'($urandom), 8'($urandom),
                   (ph == 3) ? 16'($urandom_range(1, 65535)) : 16'($urandom_range(1, 30)),
                   8'($urandom));
         idle_on = (ph != 1);
         tick_mix = (ph == 2) ? 0 : 3;
         target += 80;
         while (n_used < target) begin
            code = 8'($urandom);
            case ($urandom_range(3))
               0: cap = 16'd0;
               1: cap = 16'($urandom_range(1, 12));
               2: cap = 16'hFFFF;
               default: cap = 16'($urandom);
            endcase
            r = $urandom_range(99);
            if (r < 4) begin
               len = 16'($urandom_range(251, 65535));
            end else if (r < 6) begin
               len = 16'($urandom_range(240, 250));
            end else begin
               len = 16'($urandom_range(0, 12));
            end
            echo = ($urandom_range(19) == 0) ? 8'($urandom)
                                             : (code | crc8rx_pkg::REPLY_FLAG);
            r = $urandom_range(19);
            fault = (r < 2) ? FAULT_END : (r < 4) ? FAULT_CRC : (r < 5) ? FAULT_CUT
                                                                          : FAULT_NONE;
            r = $urandom_range(99);
            if (r < 8) begin
               repeat ($urandom_range(1, 4)) begin
                  send_item(2'($urandom_range(1, 3)), 8'($urandom), 16'($urandom),
                            8'($urandom));
               end
            end else if (r < 16) begin
               arm(code, cap);
               repeat ((sb.timeout <= 64) ? sb.timeout + $urandom_range(0, 2)
                                          : $urandom_range(1, 5)) begin
                  tick();
               end
            end else if (r < 24) begin
               arm(code, cap);
               send_frame(echo, len, FAULT_CUT);
               arm(code, cap);
               send_frame(code | crc8rx_pkg::REPLY_FLAG, 16'($urandom_range(0, 8)),
                          FAULT_NONE);
            end else begin
               arm(code, cap);
               repeat ($urandom_range(0, 2)) send_byte(8'($urandom));
               send_frame(echo, len, fault);
            end
            if ($urandom_range(49) == 0) begin
               hold_req = $urandom_range(20, 60);
            end
            if ($urandom_range(19) == 0) begin
               pause_until_drained();
            end
         end
      end

      pause_until_drained();
      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
